/* rtl/graph_degeneracy_order_defines.svh */
`ifndef GRAPH_DEGENERACY_ORDER_DEFINES_SVH
`define GRAPH_DEGENERACY_ORDER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define GDO_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define GDO_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/gdo_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package gdo_pkg;

  localparam int ACT_W = 2;
  localparam int VTX_W = 5;
  localparam int DEG_W = 5;
  localparam int CFG_W = 6;

  localparam logic [ACT_W-1:0] ACT_ADD   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RUN   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  localparam logic [CFG_W-1:0] VC_RESET = 6'd32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_A,
    ST_ADD_B,
    ST_ADD_W,
    ST_INIT,
    ST_EMIT,
    ST_SCAN
  } gdo_state_t;

  typedef enum logic [1:0] {
    ADJ_A,
    ADJ_B,
    ADJ_IDX,
    ADJ_BEST
  } adj_sel_t;

  typedef struct packed {
    logic     latch_in;
    logic     clear;
    logic     run_start;
    logic     sweep_start;
    logic     sweep_en;
    logic     init_mode;
    logic     adj_rd;
    adj_sel_t adj_sel;
    logic     wr_a;
    logic     wr_b;
    logic     emit;
  } gdo_cmd_t;

  typedef struct packed {
    logic edge_ok;
    logic dup;
    logic n_zero;
    logic sweep_done;
    logic last_step;
  } gdo_sts_t;

endpackage

`default_nettype wire

/* rtl/gdo_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module gdo_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [gdo_pkg::ACT_W-1:0] in_action,
  input  wire gdo_pkg::gdo_sts_t         sts,
  output gdo_pkg::gdo_cmd_t              cmd,
  output logic                           busy
);
  import gdo_pkg::*;

  gdo_state_t state_r;
  gdo_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_action)
            ACT_ADD: state_nxt = ST_ADD_A;
            ACT_RUN: state_nxt = sts.n_zero ? ST_IDLE : ST_INIT;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ADD_A: state_nxt = sts.edge_ok ? ST_ADD_B : ST_IDLE;
      ST_ADD_B: state_nxt = sts.dup ? ST_IDLE : ST_ADD_W;
      ST_ADD_W: state_nxt = ST_IDLE;
      ST_INIT:  state_nxt = sts.sweep_done ? ST_EMIT : ST_INIT;
      ST_EMIT:  state_nxt = sts.last_step ? ST_IDLE : ST_SCAN;
      ST_SCAN:  state_nxt = sts.sweep_done ? ST_EMIT : ST_SCAN;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.latch_in = 1'b1;
          case (in_action)
            ACT_RUN: begin
              cmd.run_start   = 1'b1;
              cmd.sweep_start = 1'b1;
            end
            ACT_CLEAR: cmd.clear = 1'b1;
            default: ;
          endcase
        end
      end
      ST_ADD_A: begin
        cmd.adj_rd  = 1'b1;
        cmd.adj_sel = ADJ_A;
      end
      ST_ADD_B: begin
        cmd.wr_a    = !sts.dup;
        cmd.adj_rd  = 1'b1;
        cmd.adj_sel = ADJ_B;
      end
      ST_ADD_W: cmd.wr_b = 1'b1;
      ST_INIT: begin
        cmd.sweep_en  = 1'b1;
        cmd.init_mode = 1'b1;
        cmd.adj_rd    = 1'b1;
        cmd.adj_sel   = ADJ_IDX;
      end
      ST_EMIT: begin
        cmd.emit        = 1'b1;
        cmd.sweep_start = 1'b1;
        cmd.adj_rd      = 1'b1;
        cmd.adj_sel     = ADJ_BEST;
      end
      ST_SCAN: cmd.sweep_en = 1'b1;
      default: ;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

`default_nettype wire

/* rtl/gdo_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "graph_degeneracy_order_defines.svh"

module gdo_datapath #(
  parameter int MAX_VERTICES = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire gdo_pkg::gdo_cmd_t         cmd,
  output gdo_pkg::gdo_sts_t              sts,
  input  wire logic [gdo_pkg::CFG_W-1:0] cfg_count,
  input  wire logic [gdo_pkg::VTX_W-1:0] in_vertex_a,
  input  wire logic [gdo_pkg::VTX_W-1:0] in_vertex_b,
  output logic                           out_strobe,
  output logic [gdo_pkg::VTX_W-1:0]      out_removed_vertex,
  output logic [gdo_pkg::DEG_W-1:0]      out_removal_degree,
  output logic [gdo_pkg::DEG_W-1:0]      out_degeneracy,
  output logic                           out_last
);
  import gdo_pkg::*;

  localparam int IW  = $clog2(MAX_VERTICES);
  localparam int NW  = $clog2(MAX_VERTICES + 1);
  localparam int NCH = (MAX_VERTICES + 7) / 8;
  localparam int PW  = NCH * 8;

  // effective vertex count, saturated to MAX_VERTICES
  logic [6:0]              n_ext;
  logic [NW-1:0]           n;
  logic [MAX_VERTICES-1:0] amask;

  assign n_ext = ({1'b0, cfg_count} > 7'(MAX_VERTICES)) ? 7'(MAX_VERTICES)
                                                        : {1'b0, cfg_count};
  assign n = NW'(n_ext);

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      amask[i] = (i < int'(n));
    end
  end

  // latched edge endpoints
  logic [VTX_W-1:0] a_r, b_r;
  logic [IW-1:0]    a_idx, b_idx;

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      a_r <= in_vertex_a;
      b_r <= in_vertex_b;
    end
  end

  assign a_idx = IW'(a_r);
  assign b_idx = IW'(b_r);

  // adjacency memory, row valid bits stand in for the clear
  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_valid_r;
  logic [MAX_VERTICES-1:0] adj_q_r;
  logic                    adj_qv_r;
  logic [MAX_VERTICES-1:0] adj_row;
  logic [IW-1:0]           adj_raddr;
  logic [IW-1:0]           adj_waddr;
  logic [MAX_VERTICES-1:0] adj_wdata;
  logic                    adj_we;
  logic [MAX_VERTICES-1:0] one_vec;

  // sweep and min search state
  logic [NW-1:0]           i_r;
  logic                    p_vld_r;
  logic [IW-1:0]           p_idx_r;
  logic                    issue;
  logic                    found_r;
  logic [IW-1:0]           best_r;
  logic [IW-1:0]           best_deg_r;
  logic [MAX_VERTICES-1:0] removed_r;
  logic [IW-1:0]           max_r;
  logic [IW-1:0]           new_max;
  logic [NW-1:0]           step_r;

  assign one_vec = {{(MAX_VERTICES-1){1'b0}}, 1'b1};

  always_comb begin
    case (cmd.adj_sel)
      ADJ_A:    adj_raddr = a_idx;
      ADJ_B:    adj_raddr = b_idx;
      ADJ_IDX:  adj_raddr = i_r[IW-1:0];
      ADJ_BEST: adj_raddr = best_r;
      default:  adj_raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.adj_rd) begin
      adj_q_r  <= adj_mem[adj_raddr];
      adj_qv_r <= row_valid_r[adj_raddr];
    end
  end

  assign adj_row   = adj_qv_r ? adj_q_r : '0;
  assign adj_we    = cmd.wr_a | cmd.wr_b;
  assign adj_waddr = cmd.wr_a ? a_idx : b_idx;
  assign adj_wdata = adj_row | (one_vec << (cmd.wr_a ? b_idx : a_idx));

  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
    end else if (cmd.clear) begin
      row_valid_r <= '0;
    end else if (adj_we) begin
      row_valid_r <= row_valid_r | (one_vec << adj_waddr);
    end
  end

  // masked popcount of the row read back: bytes first, then the byte sums
  logic [PW-1:0] pc_row;
  logic [3:0]    chunk_cnt;
  logic [NW-1:0] pc_sum;

  always_comb begin
    pc_row = PW'(adj_row & amask);
    pc_sum = '0;
    chunk_cnt = '0;
    for (int c = 0; c < NCH; c++) begin
      chunk_cnt = '0;
      for (int k = 0; k < 8; k++) begin
        chunk_cnt = chunk_cnt + 4'(pc_row[c*8+k]);
      end
      pc_sum = pc_sum + NW'(chunk_cnt);
    end
  end

  // degree memory
  logic [IW-1:0] deg_mem [MAX_VERTICES];
  logic [IW-1:0] deg_q_r;
  logic          dec;
  logic [IW-1:0] val;
  logic          cand;

  assign issue = cmd.sweep_en && (i_r < n);

  always_ff @(posedge clk) begin
    if (issue && !cmd.init_mode) begin
      deg_q_r <= deg_mem[i_r[IW-1:0]];
    end
  end

  assign dec  = adj_row[p_idx_r] & !removed_r[p_idx_r] & (deg_q_r != '0);
  assign val  = cmd.init_mode ? IW'(pc_sum) : (deg_q_r - IW'(dec));
  assign cand = p_vld_r && !removed_r[p_idx_r];

  always_ff @(posedge clk) begin
    if (p_vld_r) begin
      deg_mem[p_idx_r] <= val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r     <= '0;
      p_vld_r <= 1'b0;
    end else if (cmd.sweep_start) begin
      i_r     <= '0;
      p_vld_r <= 1'b0;
    end else if (cmd.sweep_en) begin
      p_vld_r <= issue;
      if (issue) begin
        i_r <= i_r + NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p_idx_r <= i_r[IW-1:0];
    end
  end

  // lowest degree wins, strict compare keeps the lowest index on ties
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (cmd.sweep_start) begin
      found_r <= 1'b0;
    end else if (cand && (!found_r || val < best_deg_r)) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!cmd.sweep_start && cand && (!found_r || val < best_deg_r)) begin
      best_r     <= p_idx_r;
      best_deg_r <= val;
    end
  end

  assign new_max = (best_deg_r > max_r) ? best_deg_r : max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      removed_r <= '0;
      max_r     <= '0;
      step_r    <= '0;
    end else if (cmd.run_start) begin
      removed_r <= '0;
      max_r     <= '0;
      step_r    <= '0;
    end else if (cmd.emit) begin
      removed_r <= removed_r | (one_vec << best_r);
      max_r     <= new_max;
      step_r    <= step_r + NW'(1);
    end
  end

  // result register
  logic             out_vld_r;
  logic [VTX_W-1:0] out_vertex_r;
  logic [DEG_W-1:0] out_deg_r;
  logic [DEG_W-1:0] out_dgn_r;
  logic             out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_vertex_r <= VTX_W'(best_r);
      out_deg_r    <= DEG_W'(best_deg_r);
      out_dgn_r    <= DEG_W'(new_max);
      out_last_r   <= sts.last_step;
    end
  end

  assign out_strobe         = out_vld_r;
  assign out_removed_vertex = out_vertex_r;
  assign out_removal_degree = out_deg_r;
  assign out_degeneracy     = out_dgn_r;
  assign out_last           = out_last_r;

  // status
  assign sts.edge_ok    = (a_r != b_r) && ({2'b00, a_r} < n_ext) && ({2'b00, b_r} < n_ext);
  assign sts.dup        = adj_row[b_idx];
  assign sts.n_zero     = (n == '0);
  assign sts.sweep_done = (i_r == n) && !p_vld_r;
  assign sts.last_step  = ((step_r + NW'(1)) == n);

  `GDO_ASSERT_IMP(a_emit_found, cmd.emit, found_r, "removal without a candidate")
  `GDO_ASSERT_IMP(a_emit_fresh, cmd.emit, !removed_r[best_r], "vertex removed twice")
  `GDO_ASSERT_NXT(a_emit_count, cmd.emit && !cmd.run_start,
                  $countones(removed_r) == $past($countones(removed_r)) + 1,
                  "removed set did not grow by one")
  `GDO_ASSERT_IMP(a_out_range, out_vld_r, {2'b00, out_vertex_r} < n_ext,
                  "result vertex outside active range")

endmodule

`default_nettype wire

/* rtl/graph_degeneracy_order.sv */
`timescale 1ns / 1ps
`default_nettype none

// Edge beat: busy through states ADD_A, ADD_B and ADD_W (an ignored edge ends early);
// clear beat: done at acceptance. Run beat, n = effective vertex count: a degree init
// sweep, then one result strobe per removal (one removal, then a sweep of the degree
// memory at one read per cycle). Results cannot be stalled: one strobe cycle each.
// Reset (rst_n low, synchronous): graph emptied via row valid bits, vertex_count = 32.

module graph_degeneracy_order #(
  parameter int MAX_VERTICES = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // command channel
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [gdo_pkg::ACT_W-1:0] in_action,
  input  wire logic [gdo_pkg::VTX_W-1:0] in_vertex_a,
  input  wire logic [gdo_pkg::VTX_W-1:0] in_vertex_b,
  // result channel
  output logic                           out_strobe,
  output logic [gdo_pkg::VTX_W-1:0]      out_removed_vertex,
  output logic [gdo_pkg::DEG_W-1:0]      out_removal_degree,
  output logic [gdo_pkg::DEG_W-1:0]      out_degeneracy,
  output logic                           out_last,
  // configuration channel
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [gdo_pkg::CFG_W-1:0] cfg_vertex_count
);
  import gdo_pkg::*;

  // vertex_count register, always ready; user keeps writes to idle, block does not enforce
  logic [CFG_W-1:0] vc_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= VC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      vc_r <= cfg_vertex_count;
    end
  end

  gdo_cmd_t cmd;
  gdo_sts_t sts;

  // sequencer: edge load, clear, init sweep, remove/scan loop
  gdo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  // adjacency and degree memories, min search, result register
  gdo_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_count          (vc_r),
    .in_vertex_a        (in_vertex_a),
    .in_vertex_b        (in_vertex_b),
    .out_strobe         (out_strobe),
    .out_removed_vertex (out_removed_vertex),
    .out_removal_degree (out_removal_degree),
    .out_degeneracy     (out_degeneracy),
    .out_last           (out_last)
  );

endmodule

`default_nettype wire
